// ----- design/isp_pkg.sv -----
// Shared constants, record type and helper function for the script stream parser.
package isp_pkg;

	localparam logic [7:0]  END_OF_TABLE = 8'h55;
	localparam logic [7:0]  END_OF_SEQ   = 8'hFE;
	localparam logic [7:0]  FIELD_MASK   = 8'h1F;
	localparam int          FLAG_BIT_POS = 5;
	localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;
	localparam logic [15:0] CHECK_BACK   = 16'd2;

	typedef enum logic [2:0] {
		KIND_HEADER    = 3'd0,
		KIND_TIMETABLE = 3'd1,
		KIND_COMMAND   = 3'd2,
		KIND_PARAM     = 3'd3,
		KIND_CHECKSUM  = 3'd4
	} rec_kind_t;

	typedef struct packed {
		rec_kind_t   rec_kind;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [7:0]  byte_c;
		logic [7:0]  byte_d;
		logic [7:0]  byte_e;
		logic [7:0]  byte_f;
		logic [7:0]  seq_count_byte;
		logic [15:0] script_len;
		logic [7:0]  seq_index;
		logic [7:0]  item_index;
		logic        is_last;
	} rec_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

// ----- design/isp_byte_if.sv -----
// Input byte channel: valid/ready handshake carrying one script byte per beat.
interface isp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] script_byte;
	logic       first_byte;

	modport source (output valid, output script_byte, output first_byte, input ready);
	modport sink   (input valid, input script_byte, input first_byte, output ready);
endinterface

// ----- design/isp_rec_if.sv -----
// Output record channel: valid/ready handshake carrying one parsed record per beat.
interface isp_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  rec_kind;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic [7:0]  byte_c;
	logic [7:0]  byte_d;
	logic [7:0]  byte_e;
	logic [7:0]  byte_f;
	logic [7:0]  seq_count_byte;
	logic [15:0] script_len;
	logic [7:0]  seq_index;
	logic [7:0]  item_index;
	logic        is_last;

	modport source (output valid, output rec_kind, output word_a, output word_b,
		output byte_c, output byte_d, output byte_e, output byte_f,
		output seq_count_byte, output script_len, output seq_index,
		output item_index, output is_last, input ready);
	modport sink (input valid, input rec_kind, input word_a, input word_b,
		input byte_c, input byte_d, input byte_e, input byte_f,
		input seq_count_byte, input script_len, input seq_index,
		input item_index, input is_last, output ready);
endinterface

// ----- design/isp_inreg.sv -----
// Input stage register that holds one accepted script byte.
module isp_inreg (
	input  logic       clk,
	input  logic       arst_n,
	isp_byte_if.sink   script_in,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       first_s1
);

	// The stage can refill in the same cycle that its byte moves on.
	assign script_in.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (script_in.ready) begin
			valid_s1 <= script_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (script_in.valid && script_in.ready) begin
			byte_s1  <= script_in.script_byte;
			first_s1 <= script_in.first_byte;
		end
	end

endmodule

// ----- design/isp_parser.sv -----
// Parser state and per-byte decode: updates the parse state and forms at most one record.
module isp_parser
	import isp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] script_byte,
	input  logic       first_byte,
	output logic       rec_valid,
	output rec_t       rec
);

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_TIMETABLE = 3'd1,
		PH_CMD_HEAD  = 3'd2,
		PH_CMD_BODY  = 3'd3,
		PH_CHECK_LO  = 3'd4,
		PH_DONE      = 3'd5
	} phase_t;

	phase_t      phase_q, e_phase, n_phase;
	logic [15:0] off_q, e_off, n_off;
	logic [31:0] ws_q, e_ws, n_ws;
	logic [31:0] start_q, e_start, n_start;
	logic [15:0] len_q, e_len, n_len;
	logic [7:0]  flag_q, e_flag, n_flag;
	logic [31:0] hb_q, e_hb, n_hb;
	logic [7:0]  br_q, e_br, n_br;
	logic [7:0]  seq_q, e_seq, n_seq;
	logic [7:0]  ent_q, e_ent, n_ent;
	logic [7:0]  chk_q, e_chk, n_chk;

	logic [31:0] hb_new;
	logic [31:0] ws_new;
	logic [1:0]  ws_lane;
	logic [7:0]  body_pos;

	function automatic rec_t cmd_rec(input logic [31:0] hb, input logic [7:0] cnt,
		input logic [7:0] seq, input logic [7:0] ent);
		rec_t r;
		r                = '0;
		r.rec_kind       = KIND_COMMAND;
		r.byte_c         = hb[7:0];
		r.byte_d         = hb[15:8];
		r.byte_e         = hb[23:16];
		r.byte_f         = hb[31:24];
		r.seq_count_byte = cnt;
		r.seq_index      = seq;
		r.item_index     = ent;
		r.is_last        = (hb[23:16] == END_OF_SEQ);
		return r;
	endfunction

	always_comb begin
		// A restart mark makes this byte see the reset state.
		e_phase = first_byte ? PH_HEADER : phase_q;
		e_off   = first_byte ? '0 : off_q;
		e_ws    = first_byte ? '0 : ws_q;
		e_start = first_byte ? '0 : start_q;
		e_len   = first_byte ? '0 : len_q;
		e_flag  = first_byte ? '0 : flag_q;
		e_hb    = first_byte ? '0 : hb_q;
		e_br    = first_byte ? '0 : br_q;
		e_seq   = first_byte ? '0 : seq_q;
		e_ent   = first_byte ? '0 : ent_q;
		e_chk   = first_byte ? '0 : chk_q;

		n_phase = e_phase;
		n_off   = (e_off == OFFSET_MAX) ? e_off : e_off + 16'd1;
		n_ws    = e_ws;
		n_start = e_start;
		n_len   = e_len;
		n_flag  = e_flag;
		n_hb    = e_hb;
		n_br    = e_br;
		n_seq   = e_seq;
		n_ent   = e_ent;
		n_chk   = e_chk;

		rec       = '0;
		rec_valid = 1'b0;

		hb_new   = e_hb | ({24'b0, script_byte} << {e_br[1:0], 3'b000});
		// Offsets 2..5 and 6..9 both map onto byte lanes 0..3.
		ws_lane  = e_off[1:0] - 2'd2;
		ws_new   = e_ws | ({24'b0, script_byte} << {ws_lane, 3'b000});
		body_pos = e_hb[31:24] - e_br;

		case (e_phase)
			PH_HEADER: begin
				if (e_off == 16'd0) begin
					n_ws = {24'b0, script_byte};
				end else if (e_off == 16'd1) begin
					n_len = e_ws[15:0] | {script_byte, 8'b0};
					n_ws  = '0;
				end else if (e_off <= 16'd9) begin
					n_ws = ws_new;
					if (e_off == 16'd5) begin
						n_start = ws_new;
						n_ws    = '0;
					end
				end else if (e_off == 16'd10) begin
					n_flag = script_byte;
				end else begin
					rec.rec_kind   = KIND_HEADER;
					rec.word_a     = e_start;
					rec.word_b     = e_ws;
					rec.byte_c     = e_flag & FIELD_MASK;
					rec.byte_d     = {7'b0, e_flag[FLAG_BIT_POS]};
					rec.byte_e     = script_byte & FIELD_MASK;
					rec.byte_f     = {7'b0, script_byte[FLAG_BIT_POS]};
					rec.script_len = e_len;
					rec_valid      = 1'b1;
					n_phase        = PH_TIMETABLE;
					n_ws           = '0;
					n_hb           = '0;
					n_br           = '0;
					n_ent          = '0;
					n_seq          = '0;
				end
			end
			PH_CHECK_LO: begin
				rec.rec_kind = KIND_CHECKSUM;
				rec.word_a   = {16'b0, e_chk, script_byte};
				rec_valid    = 1'b1;
				n_phase      = PH_DONE;
			end
			PH_TIMETABLE, PH_CMD_HEAD, PH_CMD_BODY: begin
				if (e_off == e_len - CHECK_BACK) begin
					n_chk   = script_byte;
					n_phase = PH_CHECK_LO;
				end else if (e_phase == PH_TIMETABLE) begin
					if (e_br == 8'd0 && e_ent != 8'd0 && script_byte == END_OF_TABLE) begin
						n_phase = PH_CMD_HEAD;
						n_ent   = '0;
						n_hb    = '0;
						n_br    = '0;
					end else if (e_br >= 8'd3) begin
						rec.rec_kind   = KIND_TIMETABLE;
						rec.byte_c     = hb_new[7:0];
						rec.byte_d     = hb_new[15:8];
						rec.byte_e     = hb_new[23:16];
						rec.byte_f     = hb_new[31:24];
						rec.item_index = e_ent;
						rec_valid      = 1'b1;
						n_ent          = sat_inc(e_ent);
						n_hb           = '0;
						n_br           = '0;
					end else begin
						n_hb = hb_new;
						n_br = e_br + 8'd1;
					end
				end else if (e_phase == PH_CMD_HEAD) begin
					n_hb = hb_new;
					if (e_br >= 8'd3) begin
						if (script_byte == 8'd0) begin
							// Zero length: the command ends at its head.
							rec       = cmd_rec(hb_new, 8'd0, e_seq, e_ent);
							rec_valid = 1'b1;
							if (hb_new[23:16] == END_OF_SEQ) begin
								n_seq = sat_inc(e_seq);
								n_ent = '0;
							end else begin
								n_ent = sat_inc(e_ent);
							end
							n_phase = PH_CMD_HEAD;
							n_br    = '0;
							n_hb    = '0;
						end else begin
							n_phase = PH_CMD_BODY;
							n_br    = script_byte;
						end
					end else begin
						n_br = e_br + 8'd1;
					end
				end else begin
					if (body_pos == 8'd0) begin
						rec = cmd_rec(e_hb, script_byte, e_seq, e_ent);
					end else begin
						rec.rec_kind   = KIND_PARAM;
						rec.byte_c     = script_byte;
						rec.seq_index  = e_seq;
						rec.item_index = body_pos - 8'd1;
					end
					rec_valid = 1'b1;
					if (e_br <= 8'd1) begin
						if (e_hb[23:16] == END_OF_SEQ) begin
							n_seq = sat_inc(e_seq);
							n_ent = '0;
						end else begin
							n_ent = sat_inc(e_ent);
						end
						n_phase = PH_CMD_HEAD;
						n_br    = '0;
						n_hb    = '0;
					end else begin
						n_br = e_br - 8'd1;
					end
				end
			end
			default: begin
				// Script finished: bytes are dropped until the next restart mark.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			off_q   <= '0;
			ws_q    <= '0;
			start_q <= '0;
			len_q   <= '0;
			flag_q  <= '0;
			hb_q    <= '0;
			br_q    <= '0;
			seq_q   <= '0;
			ent_q   <= '0;
			chk_q   <= '0;
		end else if (step) begin
			phase_q <= n_phase;
			off_q   <= n_off;
			ws_q    <= n_ws;
			start_q <= n_start;
			len_q   <= n_len;
			flag_q  <= n_flag;
			hb_q    <= n_hb;
			br_q    <= n_br;
			seq_q   <= n_seq;
			ent_q   <= n_ent;
			chk_q   <= n_chk;
		end
	end

	a_restart_offset: assert property (@(posedge clk) disable iff (!arst_n)
		step && first_byte |=> off_q == 16'd1)
		else $error("restart byte did not set the offset to one");

	a_header_to_table: assert property (@(posedge clk) disable iff (!arst_n)
		step && rec_valid && rec.rec_kind == KIND_HEADER |=> phase_q == PH_TIMETABLE)
		else $error("header record not followed by timetable phase");

	a_checksum_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && rec_valid && rec.rec_kind == KIND_CHECKSUM |=> phase_q == PH_DONE)
		else $error("checksum record did not end the script");

	a_last_is_command: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec.is_last |-> rec.rec_kind == KIND_COMMAND)
		else $error("end-of-sequence mark on a record that is not a command");

endmodule

// ----- design/isp_outreg.sv -----
// Result register that holds one record until the downstream side takes it.
module isp_outreg
	import isp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  rec_t      rec_d,
	output logic      free,
	isp_rec_if.source rec_out
);

	logic valid_q;
	rec_t rec_q;

	assign free = !valid_q || rec_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			rec_q <= rec_d;
		end
	end

	assign rec_out.valid          = valid_q;
	assign rec_out.rec_kind       = rec_q.rec_kind;
	assign rec_out.word_a         = rec_q.word_a;
	assign rec_out.word_b         = rec_q.word_b;
	assign rec_out.byte_c         = rec_q.byte_c;
	assign rec_out.byte_d         = rec_q.byte_d;
	assign rec_out.byte_e         = rec_q.byte_e;
	assign rec_out.byte_f         = rec_q.byte_f;
	assign rec_out.seq_count_byte = rec_q.seq_count_byte;
	assign rec_out.script_len     = rec_q.script_len;
	assign rec_out.seq_index      = rec_q.seq_index;
	assign rec_out.item_index     = rec_q.item_index;
	assign rec_out.is_last        = rec_q.is_last;

endmodule

// ----- design/instrument_script_stream_parser_core.sv -----
// Top level of the instrument script stream parser: input register, decode and result register.
//
//   Channel     Role     Beat carries
//   ---------   ------   ------------------------------------------------------
//   script_in   sink     one script byte and its restart mark (first_byte)
//   rec_out     source   one parsed record: header, timetable entry, command,
//                        parameter byte, or checksum
//
// Each byte is held in the input register, where the parser decodes it
// against the parse state and loads at most one record into the result register.
// A new byte is accepted every cycle unless the input side stalls; records leave
// from the result register. The only limit on rate is the result register: when it
// is full and not being taken, the input register holds its byte and the input side stalls.
// Reset (arst_n, asynchronous) returns the parser to the header phase at offset zero.
// Bytes that complete no record (header fields, partial timetable slots, command
// heads) are consumed without producing a beat.
module instrument_script_stream_parser_core
	import isp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	isp_byte_if.sink  script_in,
	isp_rec_if.source rec_out
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       out_free;
	logic       step;
	logic       rec_valid;
	rec_t       rec;

	// The held byte moves on whenever the result register can take what it yields.
	// Bytes that yield nothing move on too, so out_free is only a conservative gate.
	assign step = valid_s1 && out_free;

	isp_inreg u_inreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.script_in(script_in),
		.take     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.first_s1 (first_s1)
	);

	// All parse state lives here; it advances exactly once per byte.
	isp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.script_byte(byte_s1),
		.first_byte (first_s1),
		.rec_valid  (rec_valid),
		.rec        (rec)
	);

	isp_outreg u_outreg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && rec_valid),
		.rec_d  (rec),
		.free   (out_free),
		.rec_out(rec_out)
	);

endmodule

// ----- tb/instrument_script_stream_parser_core_tb.sv -----
// Self-checking testbench for the instrument script stream parser core.
`timescale 1ns / 100ps

module instrument_script_stream_parser_core_tb;
	import isp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int          RANDOM_BEATS = 300;
	localparam int          SHOWN_FAILS = 10;

	// Parse phases of the byte decoder, in the order a script walks through them.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TABLE,
		PH_HEAD,
		PH_BODY,
		PH_CK_LO,
		PH_DONE
	} parse_phase_t;

	// One script byte waiting to be sent. The pace selects how much idling both
	// sides do around it (0 none, 1 short gaps, 2 short and long gaps). A drain
	// flag holds the byte back until every predicted record has come out.
	typedef struct {
		logic [7:0] data;
		logic       restart;
		logic [1:0] pace;
		bit         drain;
	} script_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	isp_byte_if byte_ch ();
	isp_rec_if  rec_ch ();

	instrument_script_stream_parser_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.script_in (byte_ch),
		.rec_out   (rec_ch)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Parser prediction. These registers mirror the decode state of the block
	// and start out in their reset values.
	// ------------------------------------------------------------------------
	logic [15:0]  at_offset = '0;
	parse_phase_t phase = PH_HEADER;
	logic [31:0]  asm_word = '0;
	logic [31:0]  start_time = '0;
	logic [15:0]  hdr_length = '0;
	logic [7:0]   flag0 = '0;
	logic [31:0]  slot_bytes = '0;
	logic [7:0]   slot_left = '0;
	logic [7:0]   seq_num = '0;
	logic [7:0]   entry_num = '0;
	logic [7:0]   checksum_hi = '0;

	rec_t         pending_records[$];
	script_beat_t byte_backlog[$];

	int           fail_count = 0;
	int unsigned  cycle_count = 0;

	// Counters that stop at their top value instead of wrapping.
	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	// Command record built from the four head bytes collected in slot_bytes.
	function automatic rec_t command_record(input logic [7:0] count);
		rec_t r;
		r = '0;
		r.rec_kind       = KIND_COMMAND;
		r.byte_c         = slot_bytes[7:0];
		r.byte_d         = slot_bytes[15:8];
		r.byte_e         = slot_bytes[23:16];
		r.byte_f         = slot_bytes[31:24];
		r.seq_count_byte = count;
		r.seq_index      = seq_num;
		r.item_index     = entry_num;
		r.is_last        = (slot_bytes[23:16] == END_OF_SEQ);
		return r;
	endfunction

	// An end-of-sequence command opens a new sequence; any other command just
	// advances the command number within the current one.
	task automatic end_command();
		if (slot_bytes[23:16] == END_OF_SEQ) begin
			seq_num   = bump(seq_num);
			entry_num = '0;
		end else begin
			entry_num = bump(entry_num);
		end
		phase      = PH_HEAD;
		slot_left  = '0;
		slot_bytes = '0;
	endtask

	// Advances the predicted parser by one accepted byte and returns the record
	// it produces, if any.
	task automatic parse_byte(input logic [7:0] b, input logic restart,
		output bit got, output rec_t r);
		logic [15:0] here;
		logic [15:0] check_at;
		logic [7:0]  pos;
		int          sh;
		got = 1'b0;
		r   = '0;
		if (restart) begin
			at_offset   = '0;
			phase       = PH_HEADER;
			asm_word    = '0;
			start_time  = '0;
			hdr_length  = '0;
			flag0       = '0;
			slot_bytes  = '0;
			slot_left   = '0;
			seq_num     = '0;
			entry_num   = '0;
			checksum_hi = '0;
		end
		here = at_offset;
		if (at_offset != OFFSET_MAX)
			at_offset = at_offset + 16'd1;
		check_at = hdr_length - CHECK_BACK;

		if (phase == PH_HEADER) begin
			// Little-endian length, start time and serial, then two flag bytes.
			if (here == 16'd0) begin
				asm_word = {24'd0, b};
			end else if (here == 16'd1) begin
				hdr_length = {b, asm_word[7:0]};
				asm_word   = '0;
			end else if (here <= 16'd9) begin
				sh = (here <= 16'd5) ? int'(here) - 2 : int'(here) - 6;
				asm_word = asm_word | ({24'd0, b} << (8 * sh));
				if (here == 16'd5) begin
					start_time = asm_word;
					asm_word   = '0;
				end
			end else if (here == 16'd10) begin
				flag0 = b;
			end else begin
				got          = 1'b1;
				r.rec_kind   = KIND_HEADER;
				r.word_a     = start_time;
				r.word_b     = asm_word;
				r.byte_c     = flag0 & FIELD_MASK;
				r.byte_d     = {7'd0, flag0[FLAG_BIT_POS]};
				r.byte_e     = b & FIELD_MASK;
				r.byte_f     = {7'd0, b[FLAG_BIT_POS]};
				r.script_len = hdr_length;
				phase        = PH_TABLE;
				asm_word     = '0;
				slot_bytes   = '0;
				slot_left    = '0;
				entry_num    = '0;
				seq_num      = '0;
			end
		end else if (phase == PH_CK_LO) begin
			got        = 1'b1;
			r.rec_kind = KIND_CHECKSUM;
			r.word_a   = {16'd0, checksum_hi, b};
			phase      = PH_DONE;
		end else if (phase == PH_DONE) begin
			// Everything after the checksum waits for a restart mark.
		end else if (here == check_at) begin
			// The checksum position wins over whatever item is in progress.
			checksum_hi = b;
			phase       = PH_CK_LO;
		end else if (phase == PH_TABLE) begin
			// The terminator is only looked for at the start of a slot, and never
			// in the very first slot.
			if (slot_left == 8'd0 && entry_num != 8'd0 && b == END_OF_TABLE) begin
				phase      = PH_HEAD;
				entry_num  = '0;
				slot_bytes = '0;
				slot_left  = '0;
			end else begin
				slot_bytes = slot_bytes | ({24'd0, b} << (8 * slot_left[1:0]));
				if (slot_left >= 8'd3) begin
					got          = 1'b1;
					r.rec_kind   = KIND_TIMETABLE;
					r.byte_c     = slot_bytes[7:0];
					r.byte_d     = slot_bytes[15:8];
					r.byte_e     = slot_bytes[23:16];
					r.byte_f     = slot_bytes[31:24];
					r.item_index = entry_num;
					entry_num    = bump(entry_num);
					slot_bytes   = '0;
					slot_left    = '0;
				end else begin
					slot_left = slot_left + 8'd1;
				end
			end
		end else if (phase == PH_HEAD) begin
			slot_bytes = slot_bytes | ({24'd0, b} << (8 * slot_left[1:0]));
			if (slot_left >= 8'd3) begin
				// A zero length field closes the command right at its head.
				if (b == 8'd0) begin
					got = 1'b1;
					r   = command_record(8'd0);
					end_command();
				end else begin
					phase     = PH_BODY;
					slot_left = b;
				end
			end else begin
				slot_left = slot_left + 8'd1;
			end
		end else begin
			// Command body: the first byte is the sequence count and completes the
			// command record, every later byte is a parameter.
			pos = slot_bytes[31:24] - slot_left;
			got = 1'b1;
			if (pos == 8'd0) begin
				r = command_record(b);
			end else begin
				r.rec_kind   = KIND_PARAM;
				r.byte_c     = b;
				r.seq_index  = seq_num;
				r.item_index = pos - 8'd1;
			end
			if (slot_left <= 8'd1)
				end_command();
			else
				slot_left = slot_left - 8'd1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Checking helpers.
	// ------------------------------------------------------------------------
	function automatic string rec_text(input rec_t r);
		return $sformatf({"kind=%0d a=%h b=%h c=%h d=%h e=%h f=%h cnt=%h len=%h ",
			"seq=%h item=%h last=%b"}, r.rec_kind, r.word_a, r.word_b, r.byte_c,
			r.byte_d, r.byte_e, r.byte_f, r.seq_count_byte, r.script_len,
			r.seq_index, r.item_index, r.is_last);
	endfunction

	// Names every field in which the two records differ; empty when they agree.
	function automatic string field_diffs(input rec_t want, input rec_t seen);
		string s;
		s = "";
		if (seen.rec_kind !== want.rec_kind)             s = {s, " rec_kind"};
		if (seen.word_a !== want.word_a)                 s = {s, " word_a"};
		if (seen.word_b !== want.word_b)                 s = {s, " word_b"};
		if (seen.byte_c !== want.byte_c)                 s = {s, " byte_c"};
		if (seen.byte_d !== want.byte_d)                 s = {s, " byte_d"};
		if (seen.byte_e !== want.byte_e)                 s = {s, " byte_e"};
		if (seen.byte_f !== want.byte_f)                 s = {s, " byte_f"};
		if (seen.seq_count_byte !== want.seq_count_byte) s = {s, " seq_count_byte"};
		if (seen.script_len !== want.script_len)         s = {s, " script_len"};
		if (seen.seq_index !== want.seq_index)           s = {s, " seq_index"};
		if (seen.item_index !== want.item_index)         s = {s, " item_index"};
		if (seen.is_last !== want.is_last)               s = {s, " is_last"};
		return s;
	endfunction

	task automatic note_fail(input string what);
		fail_count++;
		if (fail_count <= SHOWN_FAILS)
			$display("%0t: %s", $time, what);
	endtask

	// Idle length for one side: mostly none, sometimes a few cycles, rarely long.
	function automatic int unsigned pick_idle(input logic [1:0] pace);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (pace == 2'd0)
			return 0;
		if (pace == 2'd1)
			return (roll < 80) ? 0 : $urandom_range(1, 3);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Driver. It runs on the falling edge and owns these inputs of the block:
	// the byte channel and the ready of the record channel. A byte stays on the
	// bus until the monitor reports that its beat was taken.
	// ------------------------------------------------------------------------
	logic        byte_taken = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	logic [1:0]  cur_pace = 2'd2;

	always @(negedge clk) begin : feed
		script_beat_t nxt;
		logic         v;
		logic [7:0]   d;
		logic         f;
		logic         r;
		int unsigned  s;
		if (arst_n) begin
			v = byte_ch.valid;
			d = byte_ch.script_byte;
			f = byte_ch.first_byte;
			if (byte_ch.valid && byte_taken)
				v = 1'b0;
			if (!v) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (byte_backlog.size() != 0 &&
					!(byte_backlog[0].drain && pending_records.size() != 0)) begin
					nxt      = byte_backlog.pop_front();
					v        = 1'b1;
					d        = nxt.data;
					f        = nxt.restart;
					cur_pace = nxt.pace;
					gap_left = pick_idle(cur_pace);
				end
			end

			// Back-pressure on the record side follows the pace of the script
			// currently being sent, so quiet stretches are quiet on both sides.
			if (stall_left != 0) begin
				stall_left--;
				r = 1'b0;
			end else begin
				s          = pick_idle(cur_pace);
				r          = (s == 0);
				stall_left = (s == 0) ? 0 : s - 1;
			end

			byte_ch.valid       <= v;
			byte_ch.script_byte <= d;
			byte_ch.first_byte  <= f;
			rec_ch.ready        <= r;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. On the rising edge it checks a record beat against the oldest
	// prediction, then feeds an accepted byte beat into the predictor. A byte
	// taken now cannot produce a record in the same cycle, so the order of the
	// two is free.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch
		rec_t  seen;
		rec_t  want;
		rec_t  made;
		bit    got;
		string bad;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end else if (arst_n) begin
			byte_taken <= byte_ch.valid && byte_ch.ready;

			if (rec_ch.valid && rec_ch.ready) begin
				seen                = '0;
				seen.rec_kind       = rec_kind_t'(rec_ch.rec_kind);
				seen.word_a         = rec_ch.word_a;
				seen.word_b         = rec_ch.word_b;
				seen.byte_c         = rec_ch.byte_c;
				seen.byte_d         = rec_ch.byte_d;
				seen.byte_e         = rec_ch.byte_e;
				seen.byte_f         = rec_ch.byte_f;
				seen.seq_count_byte = rec_ch.seq_count_byte;
				seen.script_len     = rec_ch.script_len;
				seen.seq_index      = rec_ch.seq_index;
				seen.item_index     = rec_ch.item_index;
				seen.is_last        = rec_ch.is_last;
				if (pending_records.size() == 0) begin
					note_fail({"record with none expected: ", rec_text(seen)});
				end else begin
					want = pending_records.pop_front();
					bad  = field_diffs(want, seen);
					if (bad != "")
						note_fail({"record mismatch in", bad, "\n  expected ",
							rec_text(want), "\n  actual   ", rec_text(seen)});
				end
			end

			if (byte_ch.valid && byte_ch.ready) begin
				parse_byte(byte_ch.script_byte, byte_ch.first_byte, got, made);
				if (got)
					pending_records.push_back(made);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Script construction. Scripts are assembled byte by byte in script_image
	// and then moved into the backlog of the driver.
	// ------------------------------------------------------------------------
	logic [7:0] script_image[$];
	logic [1:0] script_pace = 2'd2;
	bit         drain_next = 1'b0;
	int         ignored_beats = 0;

	task automatic queue_byte(input logic [7:0] b, input logic restart);
		script_beat_t e;
		e.data    = b;
		e.restart = restart;
		e.pace    = script_pace;
		e.drain   = drain_next;
		byte_backlog.push_back(e);
		drain_next = 1'b0;
	endtask

	task automatic ship(input int n, input bit mark);
		for (int i = 0; i < n; i++)
			queue_byte(script_image[i], mark && i == 0);
		script_image.delete();
	endtask

	task automatic add_header(input logic [15:0] len, input logic [31:0] start,
		input logic [31:0] serial, input logic [7:0] f0, input logic [7:0] f1);
		script_image.push_back(len[7:0]);
		script_image.push_back(len[15:8]);
		for (int i = 0; i < 4; i++)
			script_image.push_back(start[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			script_image.push_back(serial[8 * i +: 8]);
		script_image.push_back(f0);
		script_image.push_back(f1);
	endtask

	// A timetable slot with random content. Except in the first slot, a leading
	// terminator byte would end the table, so it is nudged away.
	task automatic add_slot(input bit first_slot);
		logic [7:0] lead;
		lead = 8'($urandom);
		if (!first_slot && lead == END_OF_TABLE)
			lead = lead - 8'd1;
		script_image.push_back(lead);
		repeat (3) script_image.push_back(8'($urandom));
	endtask

	task automatic add_command(input logic [7:0] id, input logic [7:0] len);
		script_image.push_back(8'($urandom));
		script_image.push_back(8'($urandom));
		script_image.push_back(id);
		script_image.push_back(len);
		repeat (len) script_image.push_back(8'($urandom));
	endtask

	// Writes the true length into the header and appends the checksum bytes.
	task automatic seal_length();
		logic [15:0] total;
		total           = 16'(script_image.size() + 2);
		script_image[0] = total[7:0];
		script_image[1] = total[15:8];
		script_image.push_back(8'($urandom));
		script_image.push_back(8'($urandom));
	endtask

	initial begin : stimulus
		int          choice;
		int          n_slots;
		int          n_cmds;
		int          pace_roll;
		bit          big;
		logic [7:0]  id;
		logic [15:0] junk_len;

		byte_ch.valid       = 1'b0;
		byte_ch.script_byte = 8'd0;
		byte_ch.first_byte  = 1'b0;
		rec_ch.ready        = 1'b0;

		// Directed script one: sent right after reset without a restart mark.
		// Every header field sits at its top value and the length of 14 puts
		// the checksum where the first timetable slot would start. The bytes
		// after it must be ignored.
		add_header(16'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		script_image.push_back(8'hFF);
		script_image.push_back(8'hFF);
		ship(script_image.size(), 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(END_OF_TABLE, 1'b0);

		// Directed script two, sent only once all records so far have come out.
		// Zero header values with just the unit and mode bits set, a first slot
		// that opens with the terminator value, the real terminator, an end of
		// sequence command with no body and a command with two parameters.
		drain_next = 1'b1;
		add_header(16'd0, 32'd0, 32'd0, 8'h20, 8'h20);
		script_image.push_back(END_OF_TABLE);
		script_image.push_back(8'd0);
		script_image.push_back(8'd0);
		script_image.push_back(8'd0);
		script_image.push_back(END_OF_TABLE);
		add_command(END_OF_SEQ, 8'd0);
		add_command(8'h01, 8'd3);
		seal_length();
		ship(script_image.size(), 1'b1);

		// Random scripts: mostly well formed with random content, the rest cut
		// short, given a wrong length, followed by stray bytes, or pure noise.
		while (byte_backlog.size() - ignored_beats < RANDOM_BEATS) begin
			pace_roll   = $urandom_range(0, 9);
			script_pace = (pace_roll < 2) ? 2'd0 : (pace_roll < 5) ? 2'd1 : 2'd2;
			drain_next  = ($urandom_range(0, 9) == 0);

			add_header(16'd0, $urandom, $urandom, 8'($urandom), 8'($urandom));
			n_slots = $urandom_range(1, 5);
			for (int i = 0; i < n_slots; i++)
				add_slot(i == 0);
			script_image.push_back(END_OF_TABLE);
			big    = ($urandom_range(0, 19) == 0);
			n_cmds = big ? $urandom_range(1, 2) : $urandom_range(1, 6);
			for (int i = 0; i < n_cmds; i++) begin
				id = ($urandom_range(0, 3) == 0) ? END_OF_SEQ : 8'($urandom);
				add_command(id, big ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3)));
			end
			seal_length();

			choice = $urandom_range(0, 99);
			if (choice < 70) begin
				ship(script_image.size(), 1'b1);
			end else if (choice < 80) begin
				ship(script_image.size(), 1'b1);
				repeat ($urandom_range(1, 3)) begin
					queue_byte(8'($urandom), 1'b0);
					ignored_beats++;
				end
			end else if (choice < 88) begin
				ship($urandom_range(1, script_image.size() - 1), 1'b1);
			end else if (choice < 95) begin
				junk_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($urandom_range(0, script_image.size() + 8));
				script_image[0] = junk_len[7:0];
				script_image[1] = junk_len[15:8];
				ship(script_image.size(), 1'b1);
			end else begin
				script_image.delete();
				n_slots = $urandom_range(5, 40);
				for (int i = 0; i < n_slots; i++)
					queue_byte(8'($urandom), i == 0 || $urandom_range(0, 15) == 0);
			end
		end

		// One long script whose timetable is long enough for the entry counter
		// to saturate, followed by a command that carries the largest body and
		// a few end of sequence commands. Idling is kept short here.
		script_pace = 2'd1;
		drain_next  = 1'b1;
		add_header(16'd0, $urandom, $urandom, 8'($urandom), 8'($urandom));
		for (int i = 0; i < 260; i++)
			add_slot(i == 0);
		script_image.push_back(END_OF_TABLE);
		add_command(8'($urandom_range(0, 253)), 8'd255);
		for (int i = 0; i < 4; i++)
			add_command(END_OF_SEQ, 8'($urandom_range(0, 2)));
		seal_length();
		ship(script_image.size(), 1'b1);

		// Reset: held and then released on a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_backlog.size() != 0 || byte_ch.valid)
			@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- instrument_script_stream_parser_core.f -----
design/isp_pkg.sv
design/isp_byte_if.sv
design/isp_rec_if.sv
design/isp_inreg.sv
design/isp_parser.sv
design/isp_outreg.sv
design/instrument_script_stream_parser_core.sv
tb/instrument_script_stream_parser_core_tb.sv
